>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define CHK_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/wjcs_pkg.sv
package wjcs_pkg;
	localparam int WEIGHT_BITS = 16;
	localparam int MIN_W       = 32;
	localparam int SQ_W        = 48;
	localparam int RATIO_W     = 17;
	localparam int PROD_W      = 96;
	// Comparison width: q^2 (34 bits) times the squared-sum product (96 bits).
	localparam int CMP_W       = 130;

	localparam logic [2:0] ST_ACC  = 3'd0;
	localparam logic [2:0] ST_PROD = 3'd1;
	localparam logic [2:0] ST_JAC  = 3'd2;
	localparam logic [2:0] ST_COS  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	typedef struct packed {
		logic acc_en;
		logic snap;
		logic prod_step;
		logic div_start;
		logic div_step;
		logic cos_step;
	} cmd_t;

	typedef struct packed {
		logic prod_done;
		logic div_done;
		logic cos_done;
	} sts_t;
endpackage

>>> rtl/wjcs_dp.sv
`include "assert_macros.svh"
module wjcs_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wjcs_pkg::cmd_t                      cmd,
	output wjcs_pkg::sts_t                      sts,
	input  logic [15:0]                         weight_first,
	input  logic [15:0]                         weight_second,
	output logic [wjcs_pkg::RATIO_W-1:0]        jaccard_ratio,
	output logic [wjcs_pkg::RATIO_W-1:0]        cosine_ratio,
	output logic                                jaccard_undefined,
	output logic                                cosine_undefined
);
	logic [31:0] min_q, max_q, mn_snap_q, mx_snap_q;
	logic [47:0] dot_q, s1_q, s2_q, dot_snap_q, s1_snap_q, s2_snap_q;
	logic [15:0] w1, w2, lo, hi;

	assign w1 = weight_first;
	assign w2 = weight_second;
	assign lo = (w1 < w2) ? w1 : w2;
	assign hi = (w1 < w2) ? w2 : w1;

	// Running sums; cleared when a last word is snapped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0; max_q <= '0; dot_q <= '0; s1_q <= '0; s2_q <= '0;
		end else if (cmd.acc_en) begin
			if (cmd.snap) begin
				min_q <= '0; max_q <= '0; dot_q <= '0; s1_q <= '0; s2_q <= '0;
			end else begin
				min_q <= min_q + 32'(lo);
				max_q <= max_q + 32'(hi);
				dot_q <= dot_q + 48'(w1 * w2);
				s1_q  <= s1_q + 48'(w1 * w1);
				s2_q  <= s2_q + 48'(w2 * w2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			mn_snap_q  <= min_q + 32'(lo);
			mx_snap_q  <= max_q + 32'(hi);
			dot_snap_q <= dot_q + 48'(w1 * w2);
			s1_snap_q  <= s1_q + 48'(w1 * w1);
			s2_snap_q  <= s2_q + 48'(w2 * w2);
		end
	end

	// Squared-sum product s1*s2 by 16-bit digits of s2, one per cycle.
	// Also dot^2 is built the same way alongside.
	logic [1:0]  pcnt_q;
	logic [95:0] prod_q, dsq_q;
	logic [15:0] s2_dig, d_dig;
	assign s2_dig = s2_snap_q[pcnt_q*16 +: 16];
	assign d_dig  = dot_snap_q[pcnt_q*16 +: 16];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pcnt_q <= '0;
		else if (cmd.snap) pcnt_q <= '0;
		else if (cmd.prod_step) pcnt_q <= (pcnt_q == 2'd2) ? 2'd0 : pcnt_q + 2'd1;
	end
	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			prod_q <= '0; dsq_q <= '0;
		end else if (cmd.prod_step) begin
			prod_q <= prod_q + (96'(s1_snap_q * s2_dig) << (pcnt_q * 16));
			dsq_q  <= dsq_q + (96'(dot_snap_q * d_dig) << (pcnt_q * 16));
		end
	end
	assign sts.prod_done = cmd.prod_step && pcnt_q == 2'd2;

	// Restoring divider: 17 quotient bits of (min<<16)/max.
	logic [32:0] rem_q;
	logic [16:0] quo_q;
	logic [4:0]  dcnt_q;
	logic [48:0] num_q;
	logic [33:0] trial;
	assign trial = {rem_q, num_q[48]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_start) dcnt_q <= '0;
		else if (cmd.div_step) dcnt_q <= dcnt_q + 5'd1;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= 33'(mn_snap_q >> 1);
			num_q <= {mn_snap_q[0], 48'd0};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			if (trial >= 34'(mx_snap_q)) begin
				rem_q <= 33'(trial - 34'(mx_snap_q));
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end
	// The dividend min<<16 has 48 bits. When min is below max its top 31 bits,
	// min>>1, are below max and give no quotient bits, so they seed the remainder
	// and the remaining 17 bits iterate. Otherwise the saturation check below rules.
	assign sts.div_done = cmd.div_step && dcnt_q == 5'd16;

	// Cosine: bitwise search of largest q in [0,65536], q^2*prod <= dsq<<32.
	// With cand = q + 2^k the test value is q^2*prod + (q*prod << (k+1)) +
	// (prod << 2k), so q*prod and q^2*prod are kept and only shifts and adds remain.
	logic [16:0]  q_q, cand;
	logic [4:0]   ccnt_q, kb;
	logic [129:0] qp_q, q2p_q, lhs, rhs;
	logic         c_take;
	assign kb      = 5'd16 - ccnt_q;
	assign cand    = q_q | (17'd1 << kb);
	assign lhs     = q2p_q + (qp_q << (kb + 5'd1)) + (130'(prod_q) << {kb, 1'b0});
	assign rhs     = {2'd0, dsq_q, 32'd0};
	assign c_take  = cmd.cos_step && lhs <= rhs && cand <= 17'd65536;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ccnt_q <= '0;
		else if (cmd.div_start) ccnt_q <= '0;
		else if (cmd.cos_step) ccnt_q <= ccnt_q + 5'd1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q_q <= '0;
		else if (cmd.div_start) q_q <= '0;
		else if (c_take) q_q <= cand;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			qp_q <= '0; q2p_q <= '0;
		end else if (c_take) begin
			q2p_q <= lhs;
			qp_q  <= qp_q + (130'(prod_q) << kb);
		end
	end
	assign sts.cos_done = cmd.cos_step && ccnt_q == 5'd16;

	logic j_und, c_und, j_sat;
	assign j_und = mx_snap_q == '0;
	assign c_und = s1_snap_q == '0 || s2_snap_q == '0;
	assign j_sat = mn_snap_q >= mx_snap_q;
	assign jaccard_undefined = j_und;
	assign cosine_undefined  = c_und;
	assign jaccard_ratio = j_und ? '0 : (j_sat ? 17'd65536 : quo_q);
	assign cosine_ratio  = c_und ? '0 : q_q;

	`CHK_NEXT(a_clear, clk, arst_n, cmd.acc_en && cmd.snap, min_q == '0 && max_q == '0, "sums not cleared")
	`CHK_IMPLY(a_q_max, clk, arst_n, 1'b1, q_q <= 17'd65536, "cosine above one")
	`CHK_IMPLY(a_div, clk, arst_n, cmd.div_step, !cmd.snap, "snap during divide")
endmodule

>>> rtl/wjcs_ctrl.sv
`include "assert_macros.svh"
module wjcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           last,
	output logic           out_valid,
	input  logic           out_ready,
	output wjcs_pkg::cmd_t cmd,
	input  wjcs_pkg::sts_t sts
);
	logic [2:0] state_q, state_d;
	logic acc;
	assign in_ready  = state_q == wjcs_pkg::ST_ACC;
	assign out_valid = state_q == wjcs_pkg::ST_OUT;
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.acc_en = acc;
		cmd.snap = acc && last;
		cmd.prod_step = state_q == wjcs_pkg::ST_PROD;
		cmd.div_start = state_q == wjcs_pkg::ST_PROD;
		cmd.div_step = state_q == wjcs_pkg::ST_JAC;
		cmd.cos_step = state_q == wjcs_pkg::ST_COS;
		state_d = state_q;
		unique case (state_q)
			wjcs_pkg::ST_ACC:  if (acc && last) state_d = wjcs_pkg::ST_PROD;
			wjcs_pkg::ST_PROD: if (sts.prod_done) state_d = wjcs_pkg::ST_JAC;
			wjcs_pkg::ST_JAC:  if (sts.div_done) state_d = wjcs_pkg::ST_COS;
			wjcs_pkg::ST_COS:  if (sts.cos_done) state_d = wjcs_pkg::ST_OUT;
			wjcs_pkg::ST_OUT:  if (out_ready) state_d = wjcs_pkg::ST_ACC;
			default:           state_d = wjcs_pkg::ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= wjcs_pkg::ST_ACC;
		else state_q <= state_d;
	end

	`CHK_IMPLY(a_excl, clk, arst_n, 1'b1, !(in_ready && out_valid), "ready while result held")
	`CHK_NEXT(a_go, clk, arst_n, acc && last, state_q == wjcs_pkg::ST_PROD, "no start")
	`CHK_NEXT(a_ret, clk, arst_n, out_valid && out_ready, in_ready, "no return")
endmodule

>>> rtl/weighted_jaccard_cosine_similarity_core.sv
// Weighted Jaccard and cosine similarity core. Each input word carries one pair of
// weights from the same position of two matrices; running sums are kept of the
// minimum, maximum, product and both squares. The word with last high is counted
// and then ends the matrix: one result word follows with jaccard_ratio and
// cosine_ratio as truncated Q1.16 values (65536 is 1.0), and undefined flags for
// zero divisors (the ratio then reads 0). Non-last words are taken back to back.
// After a last word the core is busy with 3 product digit steps, 17 divider steps
// and 17 square-root search steps before the result word is offered; input is
// taken again once the result word is accepted.
`include "assert_macros.svh"
module weighted_jaccard_cosine_similarity_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] weight_first,
	input  logic [15:0] weight_second,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [16:0] jaccard_ratio,
	output logic [16:0] cosine_ratio,
	output logic        jaccard_undefined,
	output logic        cosine_undefined
);
	wjcs_pkg::cmd_t cmd;
	wjcs_pkg::sts_t sts;

	// The controller sequences accumulation, the product, divide and root search.
	wjcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.last(last), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	// The datapath holds the sums, snapshot and iterative arithmetic.
	wjcs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.weight_first(weight_first), .weight_second(weight_second),
		.jaccard_ratio(jaccard_ratio), .cosine_ratio(cosine_ratio),
		.jaccard_undefined(jaccard_undefined), .cosine_undefined(cosine_undefined)
	);

	// A result word holds steady while it waits.
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, $stable(jaccard_ratio), "result moved")
endmodule

>>> dv/tb.sv
// Self-checking bench for the weighted Jaccard / cosine similarity core.
// A directed table of matrix words runs first, then random matrices of mostly
// small sizes with random weights, a few long ones, and a last part with no idling.
// Every word accepted on the input updates a local model of the running sums; a
// word with last set pushes the predicted result word, which is compared field by
// field with the next result word taken from the core.
module tb;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] weight_first;
	logic [15:0] weight_second;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [16:0] jaccard_ratio;
	logic [16:0] cosine_ratio;
	logic        jaccard_undefined;
	logic        cosine_undefined;

	typedef struct packed {
		logic [16:0] jac;
		logic [16:0] cos;
		logic        jac_undef;
		logic        cos_undef;
	} similarity_t;

	// One row of the directed table. The check flag says whether the typed-in
	// result applies; otherwise the model alone decides.
	typedef struct {
		logic [15:0] w1;
		logic [15:0] w2;
		logic        lst;
		logic        check;
		similarity_t res;
	} row_t;

	similarity_t expected_q[$];
	int          errors;
	bit          quiet;

	logic [wjcs_pkg::MIN_W-1:0] min_acc, max_acc;
	logic [wjcs_pkg::SQ_W-1:0]  dot_acc, sq1_acc, sq2_acc;

	weighted_jaccard_cosine_similarity_core dut (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Largest q in [0, 65536] with q^2 * s1 * s2 <= dot^2 * 2^32.
	function automatic logic [16:0] cosine_q16(logic [wjcs_pkg::SQ_W-1:0] d,
			logic [wjcs_pkg::SQ_W-1:0] s1, logic [wjcs_pkg::SQ_W-1:0] s2);
		logic [wjcs_pkg::CMP_W-1:0] rhs, lhs, prod;
		logic [33:0]      qsq;
		int unsigned      lo, hi, mid;
		prod = wjcs_pkg::CMP_W'(s1) * wjcs_pkg::CMP_W'(s2);
		rhs = (wjcs_pkg::CMP_W'(d) * wjcs_pkg::CMP_W'(d)) << 32;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			qsq = 34'(mid) * 34'(mid);
			lhs = prod * wjcs_pkg::CMP_W'(qsq);
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return 17'(lo);
	endfunction

	// Adds one accepted word into the sums; on last it returns the result word.
	function automatic bit accumulate_pair(logic [15:0] a, logic [15:0] b, logic lst,
			output similarity_t r);
		logic [15:0] lo_w, hi_w;
		logic [wjcs_pkg::MIN_W+16:0] jr;
		lo_w = (a < b) ? a : b;
		hi_w = (a < b) ? b : a;
		min_acc = min_acc + wjcs_pkg::MIN_W'(lo_w);
		max_acc = max_acc + wjcs_pkg::MIN_W'(hi_w);
		dot_acc = dot_acc + wjcs_pkg::SQ_W'(a) * wjcs_pkg::SQ_W'(b);
		sq1_acc = sq1_acc + wjcs_pkg::SQ_W'(a) * wjcs_pkg::SQ_W'(a);
		sq2_acc = sq2_acc + wjcs_pkg::SQ_W'(b) * wjcs_pkg::SQ_W'(b);
		if (!lst) return 0;
		r = '{17'd0, 17'd0, 1'b0, 1'b0};
		if (max_acc == 0) r.jac_undef = 1'b1;
		else begin
			jr = ({17'd0, min_acc} << 16) / max_acc;
			r.jac = (jr > 65536) ? 17'd65536 : 17'(jr);
		end
		if (sq1_acc == 0 || sq2_acc == 0) r.cos_undef = 1'b1;
		else r.cos = cosine_q16(dot_acc, sq1_acc, sq2_acc);
		min_acc = '0;
		max_acc = '0;
		dot_acc = '0;
		sq1_acc = '0;
		sq2_acc = '0;
		return 1;
	endfunction

	// Sender: holds valid and payload until the word is accepted, then feeds the
	// accepted word to the model.
	task automatic send_word(logic [15:0] a, logic [15:0] b, logic lst);
		int          gap;
		similarity_t r;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		weight_first <= a;
		weight_second <= b;
		last <= lst;
		do @(posedge clk); while (!in_ready);
		if (accumulate_pair(a, b, lst, r))
			expected_q.push_back(r);
	endtask

	// Receiver stalls in random bursts, none in the final part.
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 14);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Result checking against the oldest expected word.
	always @(posedge clk) begin
		similarity_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (jaccard_ratio !== e.jac) begin
					$error("jaccard_ratio exp %0d got %0d", e.jac, jaccard_ratio);
					errors++;
				end
				if (cosine_ratio !== e.cos) begin
					$error("cosine_ratio exp %0d got %0d", e.cos, cosine_ratio);
					errors++;
				end
				if (jaccard_undefined !== e.jac_undef) begin
					$error("jaccard_undefined exp %0d got %0d", e.jac_undef,
						jaccard_undefined);
					errors++;
				end
				if (cosine_undefined !== e.cos_undef) begin
					$error("cosine_undefined exp %0d got %0d", e.cos_undef,
						cosine_undefined);
					errors++;
				end
			end
		end
	end

	// Typed-in results are compared with the model's, which the checker then uses.
	task automatic run_table();
		row_t        tbl[$];
		similarity_t r;
		tbl = '{
			'{16'd0, 16'd0, 1'b1, 1'b1, '{17'd0, 17'd0, 1'b1, 1'b1}},
			'{16'd5, 16'd0, 1'b1, 1'b1, '{17'd0, 17'd0, 1'b0, 1'b1}},
			'{16'd0, 16'hFFFF, 1'b1, 1'b1, '{17'd0, 17'd0, 1'b0, 1'b1}},
			'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{17'd65536, 17'd65536, 1'b0, 1'b0}},
			'{16'd7, 16'd7, 1'b1, 1'b1, '{17'd65536, 17'd65536, 1'b0, 1'b0}},
			'{16'd1, 16'd0, 1'b0, 1'b0, '{17'd0, 17'd0, 1'b0, 1'b0}},
			'{16'd0, 16'd1, 1'b1, 1'b1, '{17'd0, 17'd0, 1'b0, 1'b0}},
			'{16'hAAAA, 16'h5555, 1'b0, 1'b0, '{17'd0, 17'd0, 1'b0, 1'b0}},
			'{16'h5555, 16'hAAAA, 1'b1, 1'b0, '{17'd0, 17'd0, 1'b0, 1'b0}},
			'{16'd3, 16'd4, 1'b0, 1'b0, '{17'd0, 17'd0, 1'b0, 1'b0}},
			'{16'd4, 16'd3, 1'b0, 1'b0, '{17'd0, 17'd0, 1'b0, 1'b0}},
			'{16'hFFFF, 16'd1, 1'b1, 1'b0, '{17'd0, 17'd0, 1'b0, 1'b0}},
			'{16'd1, 16'd2, 1'b1, 1'b0, '{17'd0, 17'd0, 1'b0, 1'b0}}
		};
		foreach (tbl[i]) begin
			send_word(tbl[i].w1, tbl[i].w2, tbl[i].lst);
			if (tbl[i].check && expected_q.size() > 0) begin
				r = expected_q[$];
				if (r != tbl[i].res) begin
					$error("table row %0d: predicted jac %0d cos %0d ju %0d cu %0d",
						i, r.jac, r.cos, r.jac_undef, r.cos_undef);
					errors++;
				end
			end
		end
	endtask

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int len, sent;
		bit same;
		errors = 0;
		quiet = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		weight_first = '0;
		weight_second = '0;
		last = 1'b0;
		min_acc = '0;
		max_acc = '0;
		dot_acc = '0;
		sq1_acc = '0;
		sq2_acc = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_table();
		sent = 0;
		while (sent < 750) begin
			if (sent > 600) quiet = 1;
			// Mostly short matrices, an occasional long one.
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
			same = ($urandom_range(0, 7) == 0);
			for (int k = 0; k < len; k++) begin
				logic [15:0] a;
				a = rand_weight();
				send_word(a, same ? a : rand_weight(), k == len - 1);
				sent++;
			end
		end
		in_valid <= 1'b0;
		last <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl
rtl/wjcs_pkg.sv
rtl/wjcs_dp.sv
rtl/wjcs_ctrl.sv
rtl/weighted_jaccard_cosine_similarity_core.sv
dv/tb.sv
